>>> sv/swmed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmed_pkg
// Shared constants and the neighbour link type of the running median cells.
// ----------------------------------------------------------------------------
package swmed_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int WIN_SIZE_RST    = 3;
    localparam int WIN_CFG_BITS    = 7;
    localparam int SAMPLE_IN_BITS  = 32;
    localparam int MEDIAN_OUT_BITS = 33;

    // Flags a cell hands to its neighbour: entry present, and entry stays
    // in place (its value is not above the incoming sample).
    typedef struct packed {
        logic vld;
        logic keep;
    } swmed_link_t;

endpackage

>>> sv/swmed_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmed_cell
// One slot of the sorted window: value, age and a valid flag, updated from
// its own contents and its two neighbours on every sample transfer.
// ----------------------------------------------------------------------------
module swmed_cell #(
    parameter int SB = swmed_pkg::SAMPLE_BITS_DEF,
    parameter int AW = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       clr,
    input  logic                       flush,
    input  logic                       full,
    input  logic signed [SB-1:0]       smp,
    input  logic signed [SB-1:0]       oldest,
    // from the neighbour above (raw contents)
    input  logic signed [SB-1:0]       up_val,
    input  logic [AW-1:0]              up_age,
    input  swmed_pkg::swmed_link_t     up_link,
    // from the neighbour below (contents after removal)
    input  logic signed [SB-1:0]       lo_val,
    input  logic [AW-1:0]              lo_age,
    input  swmed_pkg::swmed_link_t     lo_link,
    // raw contents, to the neighbour below
    output logic signed [SB-1:0]       val_q,
    output logic [AW-1:0]              age_q,
    output swmed_pkg::swmed_link_t     link_q,
    // contents after removal, to the neighbour above
    output logic signed [SB-1:0]       b_val,
    output logic [AW-1:0]              b_age,
    output swmed_pkg::swmed_link_t     b_link
);
    import swmed_pkg::*;

    logic signed [SB-1:0] val_reg, val_next;
    logic [AW-1:0]        age_reg, age_next;
    logic                 vld_reg, vld_next;
    logic                 vld_eff;
    logic                 le;
    logic                 ge;

    // drop the current contents when the sample starts a new sequence
    assign vld_eff = vld_reg && !flush;
    assign le      = vld_eff && (val_reg <= smp);
    // at or above the leaving value: close the gap from above
    assign ge      = full && vld_eff && (val_reg >= oldest);

    assign val_q       = val_reg;
    assign age_q       = age_reg;
    assign link_q.vld  = vld_eff;
    assign link_q.keep = le;

    always_comb
    begin
        if (ge)
        begin
            b_val  = up_val;
            b_age  = up_age;
            b_link = up_link;
        end
        else
        begin
            b_val       = val_reg;
            b_age       = age_reg;
            b_link.vld  = vld_eff;
            b_link.keep = le;
        end
    end

    always_comb
    begin
        if (b_link.keep)
        begin
            val_next = b_val;
            age_next = b_age + AW'(1);
            vld_next = 1'b1;
        end
        else if (lo_link.keep)
        begin
            val_next = smp;
            age_next = '0;
            vld_next = 1'b1;
        end
        else
        begin
            val_next = lo_val;
            age_next = lo_age + AW'(1);
            vld_next = lo_link.vld;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (clr)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

>>> sv/sliding_window_median_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_top
// Running median over the last window_size signed samples, given doubled.
// ----------------------------------------------------------------------------
// Input channel: sample and restart, transferred when in_valid and in_ready
// are both high. Output channel: median_times_two, transferred when
// out_valid and out_ready are both high. The result is twice the median:
// twice the middle value for an odd window, the sum of the two middle values
// for an even one. No result is given until the window holds window_size
// samples; restart empties the window before its own sample is taken.
// A sample transfer sets the median stage (calc_reg); the median stage then
// loads the output register (sum_reg, out_valid) once that register is free.
// Throughput: one sample per cycle while the receiver takes results; the
// row of cells moves one step per sample and the median adder then works
// on the registered row. When the receiver stalls with a result waiting,
// in_ready drops as soon as a second result is pending in the median stage.
// Reset empties the window and sets a window of 3. A write of window_size
// (cfg_wen) takes effect at once and empties the window; sizes of zero and
// above WINDOW_MAX act as 1 and WINDOW_MAX.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
    parameter int WINDOW_MAX  = swmed_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swmed_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_wen,
    input  logic [swmed_pkg::WIN_CFG_BITS-1:0]        window_size,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [swmed_pkg::SAMPLE_IN_BITS-1:0] sample,
    input  logic                                      restart,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [swmed_pkg::MEDIAN_OUT_BITS-1:0] median_times_two
);
    import swmed_pkg::*;

    localparam int WM    = WINDOW_MAX;
    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(WM);
    localparam int KW    = $clog2(WM + 1);
    localparam int K_RST = (WIN_SIZE_RST > WM) ? WM : WIN_SIZE_RST;

    logic [KW-1:0]        k_reg, k_next;
    logic [KW-1:0]        fill_reg, fill_next;
    logic signed [SB-1:0] oldest_reg, oldest_next;
    logic                 calc_reg, calc_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SB:0]          sum_reg, sum_next;

    logic                 accept;
    logic                 calc_go;
    logic                 full;
    logic                 k_one;
    logic [AW-1:0]        age_pen;
    logic [AW-1:0]        mid_lo;
    logic [AW-1:0]        mid_hi;
    logic signed [SB-1:0] smp;
    logic signed [SB-1:0] old_sel;
    logic signed [SB:0]   lo_x;
    logic signed [SB:0]   hi_x;

    logic signed [SB-1:0] cell_val   [WM];
    logic [AW-1:0]        cell_age   [WM];
    swmed_link_t          cell_link  [WM];
    logic signed [SB-1:0] cell_bval  [WM];
    logic [AW-1:0]        cell_bage  [WM];
    swmed_link_t          cell_blink [WM];
    logic [WM-1:0]        cell_vld;

    assign smp = sample[SB-1:0];

    // Effective window size from a register write
    always_comb
    begin
        if (window_size == '0)
        begin
            k_next = KW'(1);
        end
        else if (int'(window_size) > WM)
        begin
            k_next = KW'(WM);
        end
        else
        begin
            k_next = KW'(window_size);
        end
    end

    assign k_one   = (k_reg == KW'(1));
    assign age_pen = AW'(k_reg - KW'(2));
    assign mid_lo  = AW'((k_reg - KW'(1)) >> 1);
    assign mid_hi  = AW'(k_reg >> 1);

    // Handshake: the median stage frees up when the output register can load
    assign calc_go  = calc_reg && (!out_valid_reg || out_ready);
    assign in_ready = !calc_reg || calc_go;
    assign accept   = in_valid && in_ready;

    assign full = !restart && (fill_reg == k_reg);

    always_comb
    begin
        if (full)
        begin
            fill_next = fill_reg;
        end
        else if (restart)
        begin
            fill_next = KW'(1);
        end
        else
        begin
            fill_next = fill_reg + KW'(1);
        end
    end

    // Next sample to leave: the entry one step short of the window age
    always_comb
    begin
        old_sel = '0;
        for (int i = 0; i < WM; i++)
        begin
            if (cell_link[i].vld && (cell_age[i] == age_pen))
            begin
                old_sel = old_sel | cell_val[i];
            end
        end
        oldest_next = k_one ? smp : old_sel;
    end

    always_comb
    begin
        if (accept)
        begin
            calc_next = (fill_next == k_reg);
        end
        else if (calc_go)
        begin
            calc_next = 1'b0;
        end
        else
        begin
            calc_next = calc_reg;
        end
    end

    always_comb
    begin
        if (calc_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign lo_x     = {cell_val[mid_lo][SB-1], cell_val[mid_lo]};
    assign hi_x     = {cell_val[mid_hi][SB-1], cell_val[mid_hi]};
    assign sum_next = unsigned'(lo_x + hi_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= KW'(K_RST);
            fill_reg      <= '0;
            calc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            calc_reg      <= calc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                k_reg    <= k_next;
                fill_reg <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            oldest_reg <= oldest_next;
        end
        if (calc_go)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign median_times_two = MEDIAN_OUT_BITS'(sum_reg);

    // Row of cells, lowest value at index zero
    for (genvar i = 0; i < WM; i++)
    begin : g_cell
        logic signed [SB-1:0] up_val;
        logic [AW-1:0]        up_age;
        swmed_link_t          up_link;
        logic signed [SB-1:0] lo_val;
        logic [AW-1:0]        lo_age;
        swmed_link_t          lo_link;

        if (i == WM - 1)
        begin : g_top
            assign up_val  = '0;
            assign up_age  = '0;
            assign up_link = '{vld: 1'b0, keep: 1'b0};
        end
        else
        begin : g_mid
            assign up_val  = cell_val[i+1];
            assign up_age  = cell_age[i+1];
            assign up_link = cell_link[i+1];
        end

        if (i == 0)
        begin : g_bot
            // the bottom slot takes the sample unless its entry stays
            assign lo_val  = '0;
            assign lo_age  = '0;
            assign lo_link = '{vld: 1'b1, keep: 1'b1};
        end
        else
        begin : g_low
            assign lo_val  = cell_bval[i-1];
            assign lo_age  = cell_bage[i-1];
            assign lo_link = cell_blink[i-1];
        end

        swmed_cell #(
            .SB (SB),
            .AW (AW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .load    (accept),
            .clr     (cfg_wen),
            .flush   (restart),
            .full    (full),
            .smp     (smp),
            .oldest  (oldest_reg),
            .up_val  (up_val),
            .up_age  (up_age),
            .up_link (up_link),
            .lo_val  (lo_val),
            .lo_age  (lo_age),
            .lo_link (lo_link),
            .val_q   (cell_val[i]),
            .age_q   (cell_age[i]),
            .link_q  (cell_link[i]),
            .b_val   (cell_bval[i]),
            .b_age   (cell_bage[i]),
            .b_link  (cell_blink[i])
        );

        assign cell_vld[i] = u_cell.vld_reg;
    end

    // The window never holds more samples than its size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= k_reg)
        else $error("fill count above window size");

    // Occupied cells match the fill count
    a_fill_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_vld) == int'(fill_reg))
        else $error("cell occupancy differs from fill count");

    // A sample transfer without a window_size write leaves the window non-empty
    a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_wen) |=> (fill_reg != '0))
        else $error("window empty after sample transfer");

endmodule
